>>> hw/rtl/dtsp_pkg.sv
`timescale 1ns / 1ps

package dtsp_pkg;

   // Parser phases
   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SIGNED = 3'd1,
      PH_INT    = 3'd2,
      PH_FRAC   = 3'd3,
      PH_M1     = 3'd4,
      PH_M2     = 3'd5
   } phase_type;

   // Exponent classes
   typedef enum logic [1:0] {
      CLS_FRAC8 = 2'd0,
      CLS_FRAC4 = 2'd1,
      CLS_INT   = 2'd2,
      CLS_DROP4 = 2'd3
   } class_type;

   localparam int MANT_W  = 30;
   localparam int SCALE_W = 14;
   localparam int CNT_W   = 4;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_M     = 8'h6d;
   localparam logic [7:0] CH_K     = 8'h6b;
   localparam logic [7:0] CH_T     = 8'h74;

   localparam logic [3:0] DIGIT_HALF = 4'd5;

   // Zero padding scale for short fractions: 10^n, n in 0..4
   function automatic logic [SCALE_W-1:0] pow_ten(input logic [2:0] n);
      logic [SCALE_W-1:0] r;
      case (n)
         3'd0: r = 14'd1;
         3'd1: r = 14'd10;
         3'd2: r = 14'd100;
         3'd3: r = 14'd1000;
         3'd4: r = 14'd10000;
         default: r = 14'd1;
      endcase
      return r;
   endfunction

   function automatic logic [MANT_W-1:0] mul10(input logic [MANT_W-1:0] x);
      return (x << 3) + (x << 1);
   endfunction

endpackage

>>> hw/rtl/decimal_text_to_scaled_price_top.sv
`timescale 1ns / 1ps
// The result of the ending byte passes stage A, stage B and the output register on its way to rsp.
// Throughput: one byte per cycle while rsp does not back-pressure; the parser state
//   updates on the accepted beat and the finish work runs in a 3-deep registered
//   pipeline (select, scale multiply, round and negate), so back-to-back numbers stream at full rate.
// Reset: synchronous, active high; clears parser state, pipeline valids and
//   integer_only.

module decimal_text_to_scaled_price_top (
   input  logic        clock,
   input  logic        reset,
   // configuration: integer_only
   input  logic        csr_wen,
   input  logic        csr_wdata,
   // input bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] exponent_class, [31:2] mantissa,
                                    // [33:32] trailing_bytes, [39:34] zero
   output logic        rsp_tuser    // [0] is_market
);

   localparam int MW = dtsp_pkg::MANT_W;
   localparam int SW = dtsp_pkg::SCALE_W;
   localparam int CW = dtsp_pkg::CNT_W;

   // ---------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------
   logic io_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         io_ff <= 1'b0;
      end else if (csr_wen) begin
         io_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------
   dtsp_pkg::phase_type phase_ff, phase_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] icnt_ff, icnt_in;      // integral digits, saturating
   logic [CW-1:0] fcnt_ff, fcnt_in;      // fraction digits, saturating
   logic [3:0]    first_ff, first_in;    // leading integral digit
   logic [MW-1:0] acc4_ff, acc4_in;      // integral + 4 fraction digits
   logic [MW-1:0] acc8_ff, acc8_in;      // lead digit + 8 fraction digits
   logic          rnd4_ff, rnd4_in;
   logic          rnd8_ff, rnd8_in;
   logic [MW-1:0] aint_ff, aint_in;      // all integral digits
   logic [MW-1:0] adrop_ff, adrop_in;    // integral digits less the last 4
   logic [15:0]   pend_ff, pend_in;      // last 4 integral digits

   // pipeline stage A: class chosen, operands for the scale multiply
   logic          a_v_ff, b_v_ff;
   logic [1:0]    a_cls_ff, b_cls_ff;
   logic [MW-1:0] a_val_ff;
   logic [SW-1:0] a_mul_ff;
   logic          a_rnd_ff, a_neg_ff, a_mkt_ff;
   logic [1:0]    a_trail_ff;
   // stage B: scaled value
   logic [MW-1:0] b_prod_ff;
   logic          b_rnd_ff, b_neg_ff, b_mkt_ff;
   logic [1:0]    b_trail_ff;
   // output register
   logic          o_v_ff;
   logic [1:0]    o_cls_ff;
   logic [MW-1:0] o_mant_ff;
   logic          o_mkt_ff;
   logic [1:0]    o_trail_ff;

   // Stall-all-behind pipeline: a stage moves when the one after it has room.
   logic o_free, b_free, a_free, accept;
   assign o_free     = !o_v_ff || rsp_tready;
   assign b_free     = !b_v_ff || o_free;
   assign a_free     = !a_v_ff || b_free;
   assign req_tready = a_free;
   assign accept     = req_tvalid && a_free;

   // ---------------------------------------------------------------------
   // Byte decode and next state
   // ---------------------------------------------------------------------
   logic          is_dig;
   logic [3:0]    dig;
   logic          fin, fin_mkt;
   logic [1:0]    fin_trail;

   assign is_dig = (req_tdata >= dtsp_pkg::CH_ZERO) && (req_tdata <= dtsp_pkg::CH_NINE);
   assign dig    = req_tdata[3:0];

   always_comb begin
      phase_in  = phase_ff;
      neg_in    = neg_ff;
      icnt_in   = icnt_ff;
      fcnt_in   = fcnt_ff;
      first_in  = first_ff;
      acc4_in   = acc4_ff;
      acc8_in   = acc8_ff;
      rnd4_in   = rnd4_ff;
      rnd8_in   = rnd8_ff;
      aint_in   = aint_ff;
      adrop_in  = adrop_ff;
      pend_in   = pend_ff;
      fin       = 1'b0;
      fin_mkt   = 1'b0;
      fin_trail = 2'd1;

      case (phase_ff)
         dtsp_pkg::PH_INT: begin
            if (is_dig) begin
               phase_in = dtsp_pkg::PH_INT;
            end else if (!io_ff && req_tdata == dtsp_pkg::CH_DOT) begin
               phase_in = dtsp_pkg::PH_FRAC;
            end else begin
               fin = 1'b1;
            end
         end
         dtsp_pkg::PH_FRAC: begin
            if (!is_dig) begin
               fin = 1'b1;
            end
         end
         dtsp_pkg::PH_M1: begin
            if (req_tdata == dtsp_pkg::CH_K) begin
               phase_in = dtsp_pkg::PH_M2;
            end else begin
               fin       = 1'b1;
               fin_trail = 2'd2;
            end
         end
         dtsp_pkg::PH_M2: begin
            fin = 1'b1;
            if (req_tdata == dtsp_pkg::CH_T) begin
               fin_mkt   = 1'b1;
               fin_trail = 2'd0;
            end else begin
               fin_trail = 2'd3;
            end
         end
         default: begin
            // idle or signed
            if (is_dig) begin
               phase_in = dtsp_pkg::PH_INT;
            end else if (phase_ff != dtsp_pkg::PH_SIGNED &&
                         (req_tdata == dtsp_pkg::CH_PLUS ||
                          req_tdata == dtsp_pkg::CH_MINUS)) begin
               phase_in = dtsp_pkg::PH_SIGNED;
               neg_in   = (req_tdata == dtsp_pkg::CH_MINUS);
            end else if (!io_ff && req_tdata == dtsp_pkg::CH_DOT) begin
               phase_in = dtsp_pkg::PH_FRAC;
            end else if (!io_ff && req_tdata == dtsp_pkg::CH_M) begin
               phase_in = dtsp_pkg::PH_M1;
            end else begin
               fin = 1'b1;
            end
         end
      endcase

      // Integral digit: idle, signed or integral phase
      if (is_dig && phase_ff != dtsp_pkg::PH_FRAC && phase_ff != dtsp_pkg::PH_M1 &&
          phase_ff != dtsp_pkg::PH_M2) begin
         if (icnt_ff == '0) begin
            first_in = dig;
            acc8_in  = {{(MW-4){1'b0}}, dig};
         end
         aint_in = dtsp_pkg::mul10(aint_ff) + {{(MW-4){1'b0}}, dig};
         if (icnt_ff >= 4'd4) begin
            adrop_in = dtsp_pkg::mul10(adrop_ff) + {{(MW-4){1'b0}}, pend_ff[15:12]};
         end
         pend_in = {pend_ff[11:0], dig};
         acc4_in = dtsp_pkg::mul10(acc4_ff) + {{(MW-4){1'b0}}, dig};
         if (icnt_ff != 4'd15) begin
            icnt_in = icnt_ff + 4'd1;
         end
      end

      // Fraction digit
      if (is_dig && phase_ff == dtsp_pkg::PH_FRAC) begin
         if (fcnt_ff < 4'd4) begin
            acc4_in = dtsp_pkg::mul10(acc4_ff) + {{(MW-4){1'b0}}, dig};
         end else if (fcnt_ff == 4'd4) begin
            rnd4_in = (dig >= dtsp_pkg::DIGIT_HALF);
         end
         if (fcnt_ff < 4'd8) begin
            acc8_in = dtsp_pkg::mul10(acc8_ff) + {{(MW-4){1'b0}}, dig};
         end else if (fcnt_ff == 4'd8) begin
            rnd8_in = (dig >= dtsp_pkg::DIGIT_HALF);
         end
         if (fcnt_ff != 4'd15) begin
            fcnt_in = fcnt_ff + 4'd1;
         end
      end

      // A result clears the whole number
      if (fin) begin
         phase_in = dtsp_pkg::PH_IDLE;
         neg_in   = 1'b0;
         icnt_in  = '0;
         fcnt_in  = '0;
         first_in = '0;
         acc4_in  = '0;
         acc8_in  = '0;
         rnd4_in  = 1'b0;
         rnd8_in  = 1'b0;
         aint_in  = '0;
         adrop_in = '0;
         pend_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dtsp_pkg::PH_IDLE;
         neg_ff   <= 1'b0;
         icnt_ff  <= '0;
         fcnt_ff  <= '0;
         first_ff <= '0;
         acc4_ff  <= '0;
         acc8_ff  <= '0;
         rnd4_ff  <= 1'b0;
         rnd8_ff  <= 1'b0;
         aint_ff  <= '0;
         adrop_ff <= '0;
         pend_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         icnt_ff  <= icnt_in;
         fcnt_ff  <= fcnt_in;
         first_ff <= first_in;
         acc4_ff  <= acc4_in;
         acc8_ff  <= acc8_in;
         rnd4_ff  <= rnd4_in;
         rnd8_ff  <= rnd8_in;
         aint_ff  <= aint_in;
         adrop_ff <= adrop_in;
         pend_ff  <= pend_in;
      end
   end

   // ---------------------------------------------------------------------
   // Class choice on the state as it stands before the ending byte
   // ---------------------------------------------------------------------
   logic [3:0]    lead;
   logic [1:0]    sel_cls;
   logic [MW-1:0] sel_val;
   logic [SW-1:0] sel_mul;
   logic          sel_rnd;
   logic [2:0]    pad8, pad4;

   // zero padding counts, only used while fcnt is 4..7 or 0..3 respectively
   assign lead = (icnt_ff == '0) ? 4'd0 : first_ff;
   assign pad8 = 3'd0 - fcnt_ff[2:0];
   assign pad4 = 3'd4 - fcnt_ff[2:0];

   always_comb begin
      sel_cls = dtsp_pkg::CLS_INT;
      sel_val = aint_ff;
      sel_mul = dtsp_pkg::pow_ten(3'd0);
      sel_rnd = 1'b0;
      if (io_ff) begin
         sel_cls = dtsp_pkg::CLS_INT;
         sel_val = aint_ff;
      end else if (fcnt_ff >= 4'd4 && icnt_ff <= 4'd1 && lead < dtsp_pkg::DIGIT_HALF) begin
         sel_cls = dtsp_pkg::CLS_FRAC8;
         sel_val = acc8_ff;
         if (fcnt_ff < 4'd8) begin
            sel_mul = dtsp_pkg::pow_ten(pad8);
         end
         sel_rnd = rnd8_ff;
      end else if (icnt_ff < 4'd5 ||
                   (icnt_ff == 4'd5 && lead < dtsp_pkg::DIGIT_HALF)) begin
         sel_cls = dtsp_pkg::CLS_FRAC4;
         sel_val = acc4_ff;
         if (fcnt_ff < 4'd4) begin
            sel_mul = dtsp_pkg::pow_ten(pad4);
         end
         sel_rnd = rnd4_ff;
      end else if (icnt_ff >= 4'd8) begin
         sel_cls = dtsp_pkg::CLS_DROP4;
         sel_val = adrop_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Finish pipeline
   // ---------------------------------------------------------------------
   logic [MW-1:0] prod;
   logic [MW-1:0] rounded;

   // mantissa wraps, so only the low bits of the product are kept
   assign prod    = MW'(a_val_ff * a_mul_ff);
   assign rounded = b_prod_ff + {{(MW-1){1'b0}}, b_rnd_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_v_ff <= accept && fin;
         end
         if (b_free) begin
            b_v_ff <= a_v_ff;
         end
         if (o_free) begin
            o_v_ff <= b_v_ff;
         end
      end
   end

   // stage A payload: market beats carry zero value and class
   always_ff @(posedge clock) begin
      if (a_free) begin
         a_cls_ff   <= fin_mkt ? dtsp_pkg::CLS_FRAC8 : sel_cls;
         a_val_ff   <= fin_mkt ? '0 : sel_val;
         a_mul_ff   <= sel_mul;
         a_rnd_ff   <= fin_mkt ? 1'b0 : sel_rnd;
         a_neg_ff   <= neg_ff && !fin_mkt;
         a_mkt_ff   <= fin_mkt;
         a_trail_ff <= fin_trail;
      end
      if (b_free) begin
         b_cls_ff   <= a_cls_ff;
         b_prod_ff  <= prod;
         b_rnd_ff   <= a_rnd_ff;
         b_neg_ff   <= a_neg_ff;
         b_mkt_ff   <= a_mkt_ff;
         b_trail_ff <= a_trail_ff;
      end
      if (o_free) begin
         o_cls_ff   <= b_cls_ff;
         o_mant_ff  <= b_neg_ff ? (~rounded + {{(MW-1){1'b0}}, 1'b1}) : rounded;
         o_mkt_ff   <= b_mkt_ff;
         o_trail_ff <= b_trail_ff;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {6'd0, o_trail_ff, o_mant_ff, o_cls_ff};
   assign rsp_tuser  = o_mkt_ff;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SETTLE_CYCLES = 8;    // pipeline is 3 deep, leave some slack
   localparam int HOLD_AFTER    = 25;   // result beat that starts the long back-pressure
   localparam int HOLD_CYCLES   = 300;

   // one parsed price as it appears on rsp
   typedef struct {
      dtsp_pkg::class_type         cls;
      logic [dtsp_pkg::MANT_W-1:0] mant;
      logic                        mkt;
      logic [1:0]                  trail;
   } price_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   logic [7:0]  pending_chars[$];
   price_type   expected_prices[$];
   int          mismatches = 0;

   // shadow of integer_only, changed only once no byte or result is in flight
   bit          integer_mode = 1'b0;

   // parser shadow state
   dtsp_pkg::phase_type num_phase = dtsp_pkg::PH_IDLE;
   logic        num_neg;
   logic [3:0]  num_ints, num_fracs, num_lead;
   logic [29:0] num_frac4, num_frac8;
   logic        num_round4, num_round8;
   logic [31:0] num_whole, num_whole_hi;
   logic [15:0] num_tail4;

   // sender pacing
   int          send_gap = 0;
   bit          send_gap_set = 1'b0;
   bit          send_calm = 1'b0;
   int          send_run = 0;

   // receiver pacing
   int          recv_beats = 0;
   int          recv_stall = 0;
   int          recv_hold = 0;
   bit          recv_calm = 1'b0;
   int          recv_run = 0;

   decimal_text_to_scaled_price_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // [7:0] char_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // [1:0] class, [31:2] mantissa, [33:32] trailing, [39:34] 0
      .rsp_tuser  (rsp_tuser)      // [0] is_market
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Price parser shadow
   // ------------------------------------------------------------------
   task automatic clear_number();
      num_phase    = dtsp_pkg::PH_IDLE;
      num_neg      = 1'b0;
      num_ints     = '0;
      num_fracs    = '0;
      num_lead     = '0;
      num_frac4    = '0;
      num_frac8    = '0;
      num_round4   = 1'b0;
      num_round8   = 1'b0;
      num_whole    = '0;
      num_whole_hi = '0;
      num_tail4    = '0;
   endtask

   // Feed one byte; queues the price it completes, if any.
   task automatic parse_char(input logic [7:0] ch);
      logic        is_digit, take_int, take_frac, done;
      logic [3:0]  dv, lead;
      logic [1:0]  trail;
      logic [31:0] v;
      price_type   p;
      int          k;
      is_digit  = (ch >= dtsp_pkg::CH_ZERO) && (ch <= dtsp_pkg::CH_NINE);
      dv        = ch[3:0];
      take_int  = 1'b0;
      take_frac = 1'b0;
      done      = 1'b0;
      trail     = 2'd1;
      case (num_phase)
         dtsp_pkg::PH_IDLE, dtsp_pkg::PH_SIGNED: begin
            if (is_digit) begin
               num_phase = dtsp_pkg::PH_INT;
               take_int  = 1'b1;
            end else if (num_phase == dtsp_pkg::PH_IDLE &&
                         (ch == dtsp_pkg::CH_PLUS || ch == dtsp_pkg::CH_MINUS)) begin
               num_neg   = (ch == dtsp_pkg::CH_MINUS);
               num_phase = dtsp_pkg::PH_SIGNED;
            end else if (!integer_mode && ch == dtsp_pkg::CH_DOT) begin
               num_phase = dtsp_pkg::PH_FRAC;
            end else if (!integer_mode && ch == dtsp_pkg::CH_M) begin
               num_phase = dtsp_pkg::PH_M1;
            end else begin
               done = 1'b1;
            end
         end
         dtsp_pkg::PH_INT: begin
            if (is_digit) take_int = 1'b1;
            else if (!integer_mode && ch == dtsp_pkg::CH_DOT) num_phase = dtsp_pkg::PH_FRAC;
            else done = 1'b1;
         end
         dtsp_pkg::PH_FRAC: begin
            if (is_digit) take_frac = 1'b1;
            else done = 1'b1;
         end
         dtsp_pkg::PH_M1: begin
            if (ch == dtsp_pkg::CH_K) begin
               num_phase = dtsp_pkg::PH_M2;
            end else begin
               done  = 1'b1;
               trail = 2'd2;
            end
         end
         default: begin
            if (ch == dtsp_pkg::CH_T) begin
               p.cls   = dtsp_pkg::CLS_FRAC8;
               p.mant  = '0;
               p.mkt   = 1'b1;
               p.trail = 2'd0;
               expected_prices.push_back(p);
               clear_number();
            end else begin
               done  = 1'b1;
               trail = 2'd3;
            end
         end
      endcase

      if (take_int) begin
         if (num_ints == 4'd0) begin
            num_lead  = dv;
            num_frac8 = 30'(dv);
         end
         num_whole = num_whole * 32'd10 + 32'(dv);
         // once four digits are held back, the oldest one moves into the upper sum
         if (num_ints >= 4'd4) begin
            num_whole_hi = num_whole_hi * 32'd10 + 32'(num_tail4[15:12]);
         end
         num_tail4 = {num_tail4[11:0], dv};
         num_frac4 = num_frac4 * 30'd10 + 30'(dv);
         if (num_ints < 4'd15) num_ints++;
      end

      if (take_frac) begin
         if (num_fracs < 4'd4) num_frac4 = num_frac4 * 30'd10 + 30'(dv);
         else if (num_fracs == 4'd4) num_round4 = (dv >= dtsp_pkg::DIGIT_HALF);
         if (num_fracs < 4'd8) num_frac8 = num_frac8 * 30'd10 + 30'(dv);
         else if (num_fracs == 4'd8) num_round8 = (dv >= dtsp_pkg::DIGIT_HALF);
         if (num_fracs < 4'd15) num_fracs++;
      end

      if (done) begin
         lead = (num_ints == 4'd0) ? 4'd0 : num_lead;
         if (integer_mode) begin
            p.cls = dtsp_pkg::CLS_INT;
            v     = num_whole;
         end else if (num_fracs >= 4'd4 && num_ints <= 4'd1 &&
                      lead < dtsp_pkg::DIGIT_HALF) begin
            p.cls = dtsp_pkg::CLS_FRAC8;
            v     = 32'(num_frac8);
            for (k = int'(num_fracs); k < 8; k++) v = v * 32'd10;   // pad short fraction
            v = v + 32'(num_round8);
         end else if (num_ints < 4'd5 ||
                      (num_ints == 4'd5 && lead < dtsp_pkg::DIGIT_HALF)) begin
            p.cls = dtsp_pkg::CLS_FRAC4;
            v     = 32'(num_frac4);
            for (k = int'(num_fracs); k < 4; k++) v = v * 32'd10;
            v = v + 32'(num_round4);
         end else if (num_ints >= 4'd8) begin
            p.cls = dtsp_pkg::CLS_DROP4;
            v     = num_whole_hi;
         end else begin
            p.cls = dtsp_pkg::CLS_INT;
            v     = num_whole;
         end
         if (num_neg) v = 32'd0 - v;
         p.mant  = v[dtsp_pkg::MANT_W-1:0];
         p.mkt   = 1'b0;
         p.trail = trail;
         expected_prices.push_back(p);
         clear_number();
      end
   endtask

   // ------------------------------------------------------------------
   // Text generation
   // ------------------------------------------------------------------
   task automatic push_char(input logic [7:0] c);
      pending_chars.push_back(c);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
   endtask

   // byte that closes a number; now and then an arbitrary one
   function automatic logic [7:0] end_char();
      case ($urandom_range(0, 4))
         0: return 8'h20;
         1: return 8'h2c;
         2: return 8'h3b;
         3: return 8'h0a;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_number();
      int n_int, n_frac;
      bit nines, dot;
      case ($urandom_range(0, 3))
         0: push_char(dtsp_pkg::CH_PLUS);
         1: push_char(dtsp_pkg::CH_MINUS);
         default: ;
      endcase
      // mostly short integral parts so all four classes come up; some long ones for class 3
      n_int  = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 18) : $urandom_range(0, 8);
      n_frac = $urandom_range(0, 12);
      nines  = ($urandom_range(0, 7) == 0);
      dot    = integer_mode ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 3) != 0);
      repeat (n_int) begin
         push_char(nines ? dtsp_pkg::CH_NINE
                         : 8'(dtsp_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
      if (dot) begin
         push_char(dtsp_pkg::CH_DOT);
         repeat (n_frac) begin
            push_char(nines ? dtsp_pkg::CH_NINE
                            : 8'(dtsp_pkg::CH_ZERO + $urandom_range(0, 9)));
         end
      end
      push_char(end_char());
   endtask

   task automatic push_market();
      case ($urandom_range(0, 2))
         0: push_char(dtsp_pkg::CH_PLUS);
         1: push_char(dtsp_pkg::CH_MINUS);
         default: ;
      endcase
      push_char(dtsp_pkg::CH_M);
      case ($urandom_range(0, 3))
         0: push_char(8'($urandom_range(0, 255)));
         1: begin
            push_char(dtsp_pkg::CH_K);
            push_char(8'($urandom_range(0, 255)));
         end
         default: begin
            push_char(dtsp_pkg::CH_K);
            push_char(dtsp_pkg::CH_T);
         end
      endcase
   endtask

   task automatic push_random_text(input int n_chars);
      int pick;
      while (pending_chars.size() < n_chars) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            push_number();
         end else if (pick < 80) begin
            push_market();
         end else if (pick < 88) begin
            // number with no digit: lone sign or lone dot
            case ($urandom_range(0, 2))
               0: push_char(dtsp_pkg::CH_PLUS);
               1: push_char(dtsp_pkg::CH_MINUS);
               default: push_char(dtsp_pkg::CH_DOT);
            endcase
            push_char(end_char());
         end else begin
            push_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Wait until every byte is sent and every price is back; then let the pipeline go quiet.
   task automatic settle_all();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_tvalid || expected_prices.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input bit v);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      integer_mode = v;
   endtask

   // ------------------------------------------------------------------
   // Byte driver: each byte waits a drawn number of idle cycles first
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap_set = 1'b0;
      end else begin
         if (req_tvalid && req_tready) parse_char(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (!send_gap_set && pending_chars.size() != 0) begin
               if (send_run == 0) begin
                  send_calm = !send_calm;
                  send_run  = $urandom_range(20, 80);
               end
               send_run--;
               send_gap     = send_calm ? 0 : $urandom_range(0, 12);
               send_gap_set = 1'b1;
            end
            if (send_gap_set && send_gap == 0) begin
               req_tdata    <= pending_chars.pop_front();
               req_tvalid   <= 1'b1;
               send_gap_set = 1'b0;
            end else begin
               req_tvalid <= 1'b0;
               if (send_gap_set) send_gap--;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result ready: random stalls per beat, one long hold to fill the block
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            recv_beats++;
            if (recv_beats == HOLD_AFTER) recv_hold = HOLD_CYCLES;
            if (recv_run == 0) begin
               recv_calm = !recv_calm;
               recv_run  = $urandom_range(20, 80);
            end
            recv_run--;
            recv_stall = recv_calm ? 0 : $urandom_range(0, 12);
         end
         if (recv_hold != 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else if (recv_stall != 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every result beat against the oldest expected price
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      price_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_prices.size() == 0) begin
            $error("result beat with no price expected: tdata %h tuser %b", rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_prices.pop_front();
            if (rsp_tdata[1:0] !== want.cls) begin
               $error("exponent_class expected %0d got %0d", want.cls, rsp_tdata[1:0]);
               mismatches++;
            end
            if (rsp_tdata[31:2] !== want.mant) begin
               $error("mantissa expected %0d got %0d",
                      $signed(want.mant), $signed(rsp_tdata[31:2]));
               mismatches++;
            end
            if (rsp_tuser !== want.mkt) begin
               $error("is_market expected %0d got %0d", want.mkt, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[33:32] !== want.trail) begin
               $error("trailing_bytes expected %0d got %0d", want.trail, rsp_tdata[33:32]);
               mismatches++;
            end
            if (rsp_tdata[39:34] !== 6'd0) begin
               $error("tdata padding expected 0 got %0d", rsp_tdata[39:34]);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_number();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme bytes, market token and both broken forms, lone dot,
      // negative class 3 value
      push_char(8'h00);
      push_text("-mkt");
      push_text("mk");
      push_char(8'hff);
      push_text("m+");
      push_text(".x");
      push_text("-9999999999999 ");
      // mode flips to integer-only in the middle of a number: '.' then ends it
      push_text("12");
      settle_all();
      write_mode(1'b1);
      push_text("3.");
      settle_all();
      write_mode(1'b0);

      push_random_text(550);
      settle_all();
      write_mode(1'b1);
      push_random_text(300);
      // leave a number open across the switch back to decimal mode
      push_text("7");
      settle_all();
      write_mode(1'b0);
      push_text(".25 ");
      push_random_text(270);
      settle_all();

      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/dtsp_pkg.sv
hw/rtl/decimal_text_to_scaled_price_top.sv
verif/testbench.sv
